### rtl/sdc_pkg.sv
package sdc_pkg;

	localparam int TIME_W  = 32;
	localparam int VALUE_W = 32;
	localparam int DEV_W   = 31;
	localparam int DOOR_W  = 56;
	localparam int NUM_W   = 35;
	localparam int DT_W    = 33;
	localparam int FRAC_W  = 16;
	localparam int QUO_W   = 49;
	localparam int DIV_W   = 32;
	localparam int CNT_W   = $clog2(QUO_W);
	localparam int IN_W    = 192;
	localparam int OUT_W   = 120;

	localparam logic signed [DOOR_W-1:0] DOOR_MAX = {1'b0, {(DOOR_W-1){1'b1}}};
	localparam logic signed [DOOR_W-1:0] DOOR_MIN = {1'b1, {(DOOR_W-1){1'b0}}};

	localparam logic CFG_EXC  = 1'b0;
	localparam logic CFG_COMP = 1'b1;

	typedef struct packed {
		logic [VALUE_W-1:0] sample_value;
		logic [TIME_W-1:0]  sample_time;
		logic [VALUE_W-1:0] held_value;
		logic [TIME_W-1:0]  held_time;
		logic [VALUE_W-1:0] last_value;
		logic [TIME_W-1:0]  last_time;
	} in_item_t;

endpackage

### rtl/sdc_div.sv
module sdc_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [sdc_pkg::QUO_W-1:0] dividend,
	input  logic [sdc_pkg::DIV_W-1:0] divisor,
	output logic                      done,
	output logic [sdc_pkg::QUO_W-1:0] quotient
);
	import sdc_pkg::*;

	logic [QUO_W-1:0] acc_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] dsr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DIV_W:0]   trial;
	logic             qbit;
	logic [DIV_W-1:0] rem_next;

	always_comb begin
		trial    = {rem_q, acc_q[QUO_W-1]} - {1'b0, dsr_q};
		qbit     = !trial[DIV_W];
		rem_next = qbit ? trial[DIV_W-1:0] : {rem_q[DIV_W-2:0], acc_q[QUO_W-1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QUO_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			acc_q <= {acc_q[QUO_W-2:0], qbit};
			rem_q <= rem_next;
		end
	end

	assign done     = done_q;
	assign quotient = acc_q;

endmodule

### rtl/swinging_door_compression_test.sv
// Swinging door archive decision.
// Input request on s_tvalid/s_tready/s_tdata: last archived point, held point and new
// sample (times in ticks, values signed Q16.16). One result request per input on
// m_tvalid/m_tready/m_tdata: the archive decision and both doors after the step.
// Deviations are set on cfg_we/cfg_addr/cfg_wdata; the user must write them only
// while the block is idle, as the block itself does not enforce it. When the
// exception test, a zero compression deviation or equal times settle the answer,
// the item goes from the check state straight to the finish state; otherwise the
// slopes pass through the load, divide, sign, update and cross states. The slopes
// come from two restoring dividers that produce one quotient bit per cycle over 49
// bits, and this loop makes up most of the slope path. One item is handled at a time.
// The result sits in an output register; a new item is taken while it waits.
// If the receiver stalls, a finished item holds until the output register frees.
// Reset opens both doors to the extremes and clears both deviations.
module swinging_door_compression_test (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// last_time, last_value, held_time, held_value, sample_time, sample_value
	input  logic [sdc_pkg::IN_W-1:0]      s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// archive_now, upper_door, lower_door, zero pad
	output logic [sdc_pkg::OUT_W-1:0]     m_tdata,
	input  logic                          cfg_we,
	input  logic                          cfg_addr,
	input  logic [sdc_pkg::DEV_W-1:0]     cfg_wdata
);
	import sdc_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_CHECK  = 8'b0000_0010,
		ST_LOAD   = 8'b0000_0100,
		ST_DIV    = 8'b0000_1000,
		ST_SIGN   = 8'b0001_0000,
		ST_UPDATE = 8'b0010_0000,
		ST_CROSS  = 8'b0100_0000,
		ST_FINISH = 8'b1000_0000
	} state_t;

	state_t                    state_q;
	in_item_t                  item_q;
	logic [DEV_W-1:0]          exc_q;
	logic [DEV_W-1:0]          comp_q;
	logic signed [DOOR_W-1:0]  upper_q;
	logic signed [DOOR_W-1:0]  lower_q;
	logic signed [DOOR_W-1:0]  slope_up_q;
	logic signed [DOOR_W-1:0]  slope_lo_q;
	logic signed [NUM_W-1:0]   num_up_q;
	logic signed [NUM_W-1:0]   num_lo_q;
	logic signed [DT_W-1:0]    dt_q;
	logic                      held_after_q;
	logic                      neg_up_q;
	logic                      neg_lo_q;
	logic                      arch_q;
	logic                      m_tvalid_q;
	logic [OUT_W-1:0]          m_tdata_q;

	logic signed [NUM_W-1:0]   sv_x;
	logic signed [NUM_W-1:0]   hv_x;
	logic signed [NUM_W-1:0]   lv_x;
	logic signed [NUM_W-1:0]   exc_x;
	logic signed [NUM_W-1:0]   comp_x;
	logic signed [NUM_W-1:0]   d_hold;
	logic signed [NUM_W-1:0]   d_last;
	logic                      exc_hit;
	logic                      over_dev;
	logic [NUM_W-1:0]          mag_up;
	logic [NUM_W-1:0]          mag_lo;
	logic [DT_W-1:0]           mag_dt;
	logic                      div_start;
	logic                      up_done;
	logic                      lo_done;
	logic [QUO_W-1:0]          quo_up;
	logic [QUO_W-1:0]          quo_lo;
	logic signed [DOOR_W-1:0]  q_up_x;
	logic signed [DOOR_W-1:0]  q_lo_x;
	logic                      out_free;

	always_comb begin
		sv_x     = {{(NUM_W-VALUE_W){item_q.sample_value[VALUE_W-1]}}, item_q.sample_value};
		hv_x     = {{(NUM_W-VALUE_W){item_q.held_value[VALUE_W-1]}}, item_q.held_value};
		lv_x     = {{(NUM_W-VALUE_W){item_q.last_value[VALUE_W-1]}}, item_q.last_value};
		exc_x    = {{(NUM_W-DEV_W){1'b0}}, exc_q};
		comp_x   = {{(NUM_W-DEV_W){1'b0}}, comp_q};
		d_hold   = sv_x - hv_x;
		d_last   = sv_x - lv_x;
		exc_hit  = (exc_q != '0) && (d_hold <= exc_x) && (d_hold >= -exc_x);
		over_dev = (d_last > comp_x) || (d_last < -comp_x);
		mag_up   = num_up_q[NUM_W-1] ? NUM_W'(-num_up_q) : NUM_W'(num_up_q);
		mag_lo   = num_lo_q[NUM_W-1] ? NUM_W'(-num_lo_q) : NUM_W'(num_lo_q);
		mag_dt   = dt_q[DT_W-1] ? DT_W'(-dt_q) : DT_W'(dt_q);
		q_up_x   = {{(DOOR_W-QUO_W){1'b0}}, quo_up};
		q_lo_x   = {{(DOOR_W-QUO_W){1'b0}}, quo_lo};
		out_free = !m_tvalid_q || m_tready;
	end

	assign div_start = (state_q == ST_LOAD);

	sdc_div u_div_up (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({mag_up[QUO_W-FRAC_W-1:0], {FRAC_W{1'b0}}}),
		.divisor  (mag_dt[DIV_W-1:0]),
		.done     (up_done),
		.quotient (quo_up)
	);

	sdc_div u_div_lo (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({mag_lo[QUO_W-FRAC_W-1:0], {FRAC_W{1'b0}}}),
		.divisor  (mag_dt[DIV_W-1:0]),
		.done     (lo_done),
		.quotient (quo_lo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exc_q  <= '0;
			comp_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_EXC:  exc_q  <= cfg_wdata;
				CFG_COMP: comp_q <= cfg_wdata;
				default:  ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_q <= in_item_t'(s_tdata);
		end
		if (state_q == ST_CHECK) begin
			num_up_q     <= sv_x + comp_x - lv_x;
			num_lo_q     <= sv_x - comp_x - lv_x;
			dt_q         <= {1'b0, item_q.sample_time} - {1'b0, item_q.last_time};
			held_after_q <= item_q.held_time > item_q.last_time;
		end
		if (state_q == ST_LOAD) begin
			neg_up_q <= num_up_q[NUM_W-1] ^ dt_q[DT_W-1];
			neg_lo_q <= num_lo_q[NUM_W-1] ^ dt_q[DT_W-1];
		end
		if (state_q == ST_SIGN) begin
			slope_up_q <= neg_up_q ? -q_up_x : q_up_x;
			slope_lo_q <= neg_lo_q ? -q_lo_x : q_lo_x;
		end
		if (state_q == ST_FINISH && out_free) begin
			m_tdata_q <= {{(OUT_W-2*DOOR_W-1){1'b0}}, lower_q, upper_q, arch_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			upper_q    <= DOOR_MAX;
			lower_q    <= DOOR_MIN;
			arch_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == ST_FINISH && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					priority if (exc_hit) begin
						arch_q  <= 1'b0;
						state_q <= ST_FINISH;
					end else if (comp_q == '0) begin
						arch_q  <= 1'b1;
						state_q <= ST_FINISH;
					end else if (item_q.sample_time == item_q.last_time) begin
						arch_q  <= over_dev;
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (up_done) begin
						state_q <= ST_SIGN;
					end
				end
				ST_SIGN: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					if (held_after_q) begin
						if (slope_up_q < upper_q) begin
							upper_q <= slope_up_q;
						end
						if (slope_lo_q > lower_q) begin
							lower_q <= slope_lo_q;
						end
					end else begin
						upper_q <= slope_up_q;
						lower_q <= slope_lo_q;
					end
					state_q <= ST_CROSS;
				end
				ST_CROSS: begin
					if (held_after_q && upper_q < lower_q) begin
						upper_q <= DOOR_MAX;
						lower_q <= DOOR_MIN;
						arch_q  <= 1'b1;
					end else begin
						arch_q  <= 1'b0;
					end
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		up_done == lo_done)
		else $error("slope dividers out of step");

	a_accept_check: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == ST_CHECK)
		else $error("accepted request not checked");

	a_valid_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_FINISH))
		else $error("result raised outside finish");

	a_cross_reopen: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CROSS && held_after_q && upper_q < lower_q
		|=> upper_q == DOOR_MAX && lower_q == DOOR_MIN && arch_q)
		else $error("crossed doors not reopened");

endmodule
